>>> src/tlps_pkg.sv
// ----------------------------------------------------------------------------
// tlps_pkg
// shared constants, codes and channel types of the tone and led sequencer
// ----------------------------------------------------------------------------
package tlps_pkg;

	localparam int STORE_DEPTH = 16;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
	localparam int VAL_W       = 16;
	localparam int LEN_W       = 16;
	localparam int TICK_W      = 32;
	localparam int DIV_W       = 16;
	localparam int DIV_CNT_W   = $clog2(DIV_W / 2);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_TONE = 2'd1;
	localparam logic [1:0] KIND_LED  = 2'd2;

	localparam logic [1:0] MODE_REPEAT = 2'd0;
	localparam logic [1:0] MODE_QUEUE  = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUZ_EN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LED_EN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd3;

	typedef struct packed {
		logic             tick;
		logic             add;
		logic             start;
		logic             pop;
		logic             set_play;
		logic [IDX_W-1:0] play_new;
	} chan_cmd_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic [IDX_W-1:0]  head;
		logic [IDX_W-1:0]  play;
		logic [TICK_W-1:0] ticks;
		logic [VAL_W-1:0]  rd_val;
		logic [LEN_W-1:0]  rd_len;
	} chan_stat_t;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(STORE_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

endpackage

>>> src/tlps_div.sv
// ----------------------------------------------------------------------------
// tlps_div
// shared restoring divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module tlps_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [tlps_pkg::DIV_W-1:0] num,
	input  logic [tlps_pkg::DIV_W-1:0] den,
	output logic                     done,
	output logic [tlps_pkg::DIV_W-1:0] quo,
	output logic [tlps_pkg::DIV_W-1:0] rem
);
	import tlps_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     num_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     den_q;

	logic [DIV_W:0]   r1;
	logic [DIV_W:0]   r2;
	logic             ge1;
	logic             ge2;
	logic [DIV_W-1:0] r1m;
	logic [DIV_W-1:0] r2m;

	// two dependent restoring steps
	always_comb begin
		r1  = {rem_q, num_q[DIV_W-1]};
		ge1 = r1 >= {1'b0, den_q};
		r1m = ge1 ? DIV_W'(r1 - {1'b0, den_q}) : r1[DIV_W-1:0];
		r2  = {r1m, num_q[DIV_W-2]};
		ge2 = r2 >= {1'b0, den_q};
		r2m = ge2 ? DIV_W'(r2 - {1'b0, den_q}) : r2[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W / 2 - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-3:0], ge1, ge2};
			rem_q <= r2m;
		end
	end

	assign done = done_q;
	assign quo  = num_q;
	assign rem  = rem_q;

endmodule

>>> src/tlps_chan.sv
// ----------------------------------------------------------------------------
// tlps_chan
// one ring-buffered channel: entry store, indices, fill and tick counter
// ----------------------------------------------------------------------------
module tlps_chan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tlps_pkg::chan_cmd_t        cmd,
	input  logic [tlps_pkg::VAL_W-1:0] wr_val,
	input  logic [tlps_pkg::LEN_W-1:0] wr_len,
	output tlps_pkg::chan_stat_t       stat
);
	import tlps_pkg::*;

	logic [VAL_W+LEN_W-1:0] mem [STORE_DEPTH];

	logic [IDX_W-1:0]       head_q;
	logic [IDX_W-1:0]       tail_q;
	logic [IDX_W-1:0]       play_q;
	logic [FILL_W-1:0]      fill_q;
	logic [TICK_W-1:0]      ticks_q;
	logic [VAL_W+LEN_W-1:0] rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			play_q  <= '0;
			fill_q  <= '0;
			ticks_q <= '0;
		end else begin
			// saturating count while the channel holds entries
			if (cmd.tick && fill_q != '0 && ticks_q != '1)
				ticks_q <= ticks_q + 1'b1;
			if (cmd.add) begin
				tail_q <= idx_inc(tail_q);
				fill_q <= fill_q + 1'b1;
				if (cmd.start) begin
					play_q  <= head_q;
					ticks_q <= '0;
				end
			end
			if (cmd.pop) begin
				head_q  <= idx_inc(head_q);
				play_q  <= idx_inc(play_q);
				fill_q  <= fill_q - 1'b1;
				ticks_q <= '0;
			end
			if (cmd.set_play) begin
				play_q  <= cmd.play_new;
				ticks_q <= '0;
			end
		end
	end

	// store written at tail, read at the play index
	always_ff @(posedge clk) begin
		if (cmd.add)
			mem[tail_q] <= {wr_val, wr_len};
		rd_q <= mem[play_q];
	end

	assign stat.fill   = fill_q;
	assign stat.head   = head_q;
	assign stat.play   = play_q;
	assign stat.ticks  = ticks_q;
	assign stat.rd_val = rd_q[VAL_W+LEN_W-1:LEN_W];
	assign stat.rd_len = rd_q[LEN_W-1:0];

endmodule

>>> src/tone_and_led_pattern_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tone_and_led_pattern_sequencer_unit
// tone and led pattern sequencer with two ring-buffered channels
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------------
//  s_*      | in  | s_tvalid / s_tready  | tuser: kind, tdata: freq, pattern, len
//  m_*      | out | m_tvalid / m_tready  | tuser: add_ok, tdata: buzzer, led
//  cfg_*    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  add item: accept, add state, then the result state; tick item: up to one divider
//  pass per channel, and a second pass when a channel expires in repeat mode (each pass
//  goes through the 2-bit-per-cycle divider, the second one for the repeat wrap)
//  s_tready is high only while idle; a waiting result holds the next result
//  reset clears indices, counters, outputs and config; stores are not cleared
//  cfg_ready is always high, writes go straight to the registers
// ----------------------------------------------------------------------------
module tone_and_led_pattern_sequencer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [15:0] tone_freq, [23:16] pattern_in, [39:24] length_ms
	input  logic [39:0]                     s_tdata,
	// [1:0] kind
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] buzzer_on, [16:1] buzzer_freq, [24:17] led_out, [31:25] zero
	output logic [31:0]                     m_tdata,
	// [0] add_ok
	output logic [0:0]                      m_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tlps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tlps_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tlps_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ADD   = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_QDIV  = 3'd3;
	localparam logic [2:0] S_RDIV  = 3'd4;
	localparam logic [2:0] S_READ  = 3'd5;
	localparam logic [2:0] S_DRIVE = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	// configuration
	logic [1:0]  mode_q;
	logic        buz_en_q;
	logic        led_en_q;
	logic [15:0] period_q;

	// sequencer
	logic [2:0]  state_q;
	logic        ch_q;
	logic [1:0]  kind_q;
	logic [15:0] freq_q;
	logic [7:0]  pat_q;
	logic [15:0] len_q;
	logic        ok_q;

	// driven outputs
	logic        buz_on_q;
	logic [15:0] buz_freq_q;
	logic [7:0]  led_q;

	// result register
	logic        m_valid_q;
	logic [31:0] m_data_q;
	logic        m_user_q;

	chan_cmd_t   tone_cmd;
	chan_cmd_t   led_cmd;
	chan_cmd_t   cmd;
	chan_stat_t  tone_stat;
	chan_stat_t  led_stat;
	chan_stat_t  st;

	logic             en;
	logic             accept;
	logic             out_load;
	logic             full;
	logic             add_go;
	logic             add_start;
	logic             seq_mode;
	logic             expired;
	logic [15:0]      period;
	logic             div_start;
	logic [DIV_W-1:0] div_num;
	logic [DIV_W-1:0] div_den;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;
	logic [DIV_W-1:0] div_rem;
	logic [IDX_W:0]   off;
	logic [IDX_W:0]   off_nx;
	logic [IDX_W:0]   play_sum;
	logic [IDX_W-1:0] play_nx;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	// result register takes the finished item once it is empty or drains
	assign out_load  = (state_q == S_OUT) && (!m_valid_q || m_tready);

	assign st       = ch_q ? led_stat : tone_stat;
	assign en       = ch_q ? led_en_q : buz_en_q;
	assign full     = st.fill >= FILL_W'(STORE_DEPTH);
	assign seq_mode = (mode_q == MODE_REPEAT) || (mode_q == MODE_QUEUE);
	assign period   = (period_q == '0) ? 16'd1 : period_q;
	assign add_go   = (state_q == S_ADD) && (len_q != '0) && en && !full;
	assign add_start = add_go && (mode_q == MODE_QUEUE) && (st.fill == '0);
	assign expired  = st.ticks >= TICK_W'(div_quo);

	// repeat wrap: step the offset from head, modulo the fill count
	always_comb begin
		off      = {1'b0, st.play} - {1'b0, st.head};
		if (st.play < st.head)
			off = off + (IDX_W + 1)'(STORE_DEPTH);
		off_nx   = off + 1'b1;
		play_sum = {1'b0, st.head} + {1'b0, div_rem[IDX_W-1:0]};
		if (play_sum >= (IDX_W + 1)'(STORE_DEPTH))
			play_sum = play_sum - (IDX_W + 1)'(STORE_DEPTH);
		play_nx  = play_sum[IDX_W-1:0];
	end

	// shared divider operands
	always_comb begin
		div_start = 1'b0;
		div_num   = st.rd_len;
		div_den   = period;
		unique case (state_q)
			S_CHECK: div_start = seq_mode && en && (st.fill != '0);
			S_QDIV: begin
				div_start = div_done && expired && (mode_q == MODE_REPEAT);
				div_num   = DIV_W'(off_nx);
				div_den   = DIV_W'(st.fill);
			end
			default: div_start = 1'b0;
		endcase
	end

	// channel commands
	always_comb begin
		cmd          = '0;
		cmd.add      = add_go;
		cmd.start    = add_start;
		cmd.pop      = (state_q == S_QDIV) && div_done && expired && (mode_q == MODE_QUEUE);
		cmd.set_play = (state_q == S_RDIV) && div_done;
		cmd.play_new = play_nx;
		tone_cmd     = ch_q ? chan_cmd_t'('0) : cmd;
		led_cmd      = ch_q ? cmd : chan_cmd_t'('0);
		// both counters advance as the tick item is taken
		tone_cmd.tick = accept && (s_tuser == KIND_TICK);
		led_cmd.tick  = accept && (s_tuser == KIND_TICK);
	end

	tlps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	tlps_chan u_tone (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (tone_cmd),
		.wr_val (freq_q),
		.wr_len (len_q),
		.stat   (tone_stat)
	);

	tlps_chan u_led (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (led_cmd),
		.wr_val ({8'd0, pat_q}),
		.wr_len (len_q),
		.stat   (led_stat)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_REPEAT;
			buz_en_q <= 1'b1;
			led_en_q <= 1'b1;
			period_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PLAY_MODE: mode_q   <= cfg_data[1:0];
				CFG_BUZ_EN:    buz_en_q <= cfg_data[0];
				CFG_LED_EN:    led_en_q <= cfg_data[0];
				CFG_PERIOD:    period_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// item payload, held for the whole sequence
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser;
			freq_q <= s_tdata[15:0];
			pat_q  <= s_tdata[23:16];
			len_q  <= s_tdata[39:24];
		end
	end

	// sequencer and driven outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ch_q       <= 1'b0;
			ok_q       <= 1'b1;
			buz_on_q   <= 1'b0;
			buz_freq_q <= '0;
			led_q      <= '0;
			m_valid_q  <= 1'b0;
			m_user_q   <= 1'b0;
			m_data_q   <= '0;
		end else begin
			// a new load wins over the drain of the old result
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ok_q <= 1'b1;
						ch_q <= (s_tuser == KIND_LED);
						if (s_tuser == KIND_TICK)
							state_q <= S_CHECK;
						else if (s_tuser == KIND_TONE || s_tuser == KIND_LED)
							state_q <= S_ADD;
						else
							state_q <= S_OUT;
					end
				end
				S_ADD: begin
					if ((len_q != '0) && en && full)
						ok_q <= 1'b0;
					// queue start drives the new entry at once
					if (add_start) begin
						if (kind_q == KIND_LED) begin
							led_q <= pat_q;
						end else begin
							buz_on_q   <= (freq_q != '0);
							buz_freq_q <= freq_q;
						end
					end
					state_q <= S_OUT;
				end
				S_CHECK: begin
					if (div_start)
						state_q <= S_QDIV;
					else if (!ch_q)
						ch_q <= 1'b1;
					else
						state_q <= S_OUT;
				end
				S_QDIV: begin
					if (div_done) begin
						if (!expired) begin
							if (!ch_q) begin
								ch_q    <= 1'b1;
								state_q <= S_CHECK;
							end else begin
								state_q <= S_OUT;
							end
						end else if (mode_q == MODE_QUEUE) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_RDIV;
						end
					end
				end
				S_RDIV: begin
					if (div_done)
						state_q <= S_READ;
				end
				S_READ: begin
					// store read of the new play index lands next cycle
					state_q <= S_DRIVE;
				end
				S_DRIVE: begin
					if (ch_q) begin
						led_q <= (st.fill == '0) ? 8'd0 : st.rd_val[7:0];
						state_q <= S_OUT;
					end else begin
						if (st.fill == '0) begin
							buz_on_q   <= 1'b0;
							buz_freq_q <= '0;
						end else begin
							buz_on_q   <= (st.rd_val != '0);
							buz_freq_q <= st.rd_val;
						end
						ch_q    <= 1'b1;
						state_q <= S_CHECK;
					end
				end
				S_OUT: begin
					if (out_load) begin
						m_user_q  <= ok_q;
						m_data_q  <= {7'd0, led_q, buz_freq_q, buz_on_q};
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_user_q;

endmodule

>>> src/tlps_checker.sv
// ----------------------------------------------------------------------------
// tlps_checker
// port-level checks of the tone and led sequencer, bound to the top level
// ----------------------------------------------------------------------------
module tlps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// one item at a time: no accept on the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted during sequencing");

	// buzzer on exactly when a nonzero frequency is driven
	a_buz_on: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[16:1] != 16'd0)))
		else $error("buzzer flag disagrees with frequency");

	// no result is offered in the cycle right after an item is taken
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared too early");

endmodule

bind tone_and_led_pattern_sequencer_unit tlps_checker u_tlps_checker (.*);

>>> tb/sv/seq_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seq_status_checker
// watches the item, result and register channels of the sequencer, keeps its
// own copy of both ring-buffered channels and compares every result item
// ----------------------------------------------------------------------------
module seq_status_checker import tlps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [39:0]           s_tdata,
	input  logic [1:0]            s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [31:0]           m_tdata,
	input  logic [0:0]            m_tuser,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    open_count,
	output int                    checked_count,
	output int                    reject_count
);

	localparam int TONE = 0;
	localparam int LED  = 1;

	typedef struct packed {
		logic        add_ok;
		logic        buz_on;
		logic [15:0] buz_hz;
		logic [7:0]  leds;
	} status_t;

	logic [1:0]  play_mode   = MODE_REPEAT;
	logic        buz_en      = 1'b1;
	logic        led_en      = 1'b1;
	logic [15:0] tick_period = 16'd1;

	logic [15:0] slot_val [0:1][0:STORE_DEPTH-1];
	logic [15:0] slot_len [0:1][0:STORE_DEPTH-1];
	int          head_idx [0:1];
	int          tail_idx [0:1];
	int          fill     [0:1];
	int          play_idx [0:1];
	logic [31:0] ticks    [0:1];

	logic        buz_on;
	logic [15:0] buz_hz;
	logic [7:0]  leds;

	status_t     status_due [$];
	int          fail_total    = 0;
	int          checked_total = 0;
	int          reject_total  = 0;

	task automatic report_fault(input string msg);
		$display("[%0t] MISMATCH %s", $time, msg);
		fail_total++;
	endtask

	function automatic logic store_entry(input int c, input logic [15:0] v,
			input logic [15:0] len, output logic started);
		started = 1'b0;
		if (fill[c] >= STORE_DEPTH)
			return 1'b0;
		if (play_mode == MODE_QUEUE && fill[c] == 0) begin
			play_idx[c] = head_idx[c];
			ticks[c]    = '0;
			started     = 1'b1;
		end
		slot_val[c][tail_idx[c]] = v;
		slot_len[c][tail_idx[c]] = len;
		tail_idx[c] = (tail_idx[c] + 1) % STORE_DEPTH;
		fill[c]++;
		return 1'b1;
	endfunction

	// true when the playing entry ran out and the play index was stepped
	function automatic logic advance_entry(input int c, input logic en,
			input int unsigned period);
		int off;
		if (!en || fill[c] == 0)
			return 1'b0;
		if (ticks[c] < slot_len[c][play_idx[c]] / period)
			return 1'b0;
		if (play_mode == MODE_QUEUE) begin
			head_idx[c] = (head_idx[c] + 1) % STORE_DEPTH;
			fill[c]--;
			play_idx[c] = (play_idx[c] + 1) % STORE_DEPTH;
		end else begin
			// wrap by fill count relative to head
			off = (play_idx[c] + STORE_DEPTH - head_idx[c]) % STORE_DEPTH;
			off = (off + 1) % fill[c];
			play_idx[c] = (head_idx[c] + off) % STORE_DEPTH;
		end
		ticks[c] = '0;
		return 1'b1;
	endfunction

	task automatic predict_status(input logic [1:0] kind, input logic [15:0] freq,
			input logic [7:0] pat, input logic [15:0] len);
		status_t     s;
		logic        ok;
		logic        started;
		logic [15:0] hz;
		int unsigned period;
		period = (tick_period == 16'd0) ? 1 : tick_period;
		ok = 1'b1;
		case (kind)
			KIND_TONE: begin
				if (len != 16'd0 && buz_en) begin
					ok = store_entry(TONE, freq, len, started);
					if (started) begin
						buz_on = (freq != 16'd0);
						buz_hz = freq;
					end
				end
			end
			KIND_LED: begin
				if (len != 16'd0 && led_en) begin
					ok = store_entry(LED, {8'd0, pat}, len, started);
					if (started)
						leds = pat;
				end
			end
			KIND_TICK: begin
				for (int c = 0; c < 2; c++)
					if (fill[c] > 0 && ticks[c] != '1)
						ticks[c]++;
				if (play_mode == MODE_REPEAT || play_mode == MODE_QUEUE) begin
					if (advance_entry(TONE, buz_en, period)) begin
						hz = (fill[TONE] == 0) ? 16'd0 : slot_val[TONE][play_idx[TONE]];
						buz_on = (hz != 16'd0);
						buz_hz = hz;
					end
					if (advance_entry(LED, led_en, period))
						leds = (fill[LED] == 0) ? 8'd0 : slot_val[LED][play_idx[LED]][7:0];
				end
			end
			default: ;
		endcase
		if (!ok)
			reject_total++;
		s.add_ok = ok;
		s.buz_on = buz_on;
		s.buz_hz = buz_hz;
		s.leds   = leds;
		status_due.push_back(s);
	endtask

	always @(posedge clk or negedge arst_n) begin
		status_t want;
		if (!arst_n) begin
			play_mode   = MODE_REPEAT;
			buz_en      = 1'b1;
			led_en      = 1'b1;
			tick_period = 16'd1;
			for (int c = 0; c < 2; c++) begin
				head_idx[c] = 0;
				tail_idx[c] = 0;
				fill[c]     = 0;
				play_idx[c] = 0;
				ticks[c]    = '0;
				for (int i = 0; i < STORE_DEPTH; i++) begin
					slot_val[c][i] = '0;
					slot_len[c][i] = '0;
				end
			end
			buz_on = 1'b0;
			buz_hz = '0;
			leds   = '0;
			status_due.delete();
		end else begin
			// results first, so an item taken in the same cycle cannot cover for one
			if (m_tvalid && m_tready) begin
				if (status_due.size() == 0) begin
					report_fault($sformatf("result item %h/%h with nothing predicted",
						m_tuser, m_tdata));
				end else begin
					want = status_due.pop_front();
					checked_total++;
					if (m_tuser[0] !== want.add_ok)
						report_fault($sformatf("add_ok got %b want %b", m_tuser[0],
							want.add_ok));
					if (m_tdata[0] !== want.buz_on)
						report_fault($sformatf("buzzer_on got %b want %b", m_tdata[0],
							want.buz_on));
					if (m_tdata[16:1] !== want.buz_hz)
						report_fault($sformatf("buzzer_freq got %h want %h", m_tdata[16:1],
							want.buz_hz));
					if (m_tdata[24:17] !== want.leds)
						report_fault($sformatf("led_out got %h want %h", m_tdata[24:17],
							want.leds));
					if (m_tdata[31:25] !== 7'd0)
						report_fault($sformatf("tdata padding got %h", m_tdata[31:25]));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PLAY_MODE: play_mode   = cfg_data[1:0];
					CFG_BUZ_EN:    buz_en      = cfg_data[0];
					CFG_LED_EN:    led_en      = cfg_data[0];
					CFG_PERIOD:    tick_period = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_status(s_tuser, s_tdata[15:0], s_tdata[23:16], s_tdata[39:24]);
		end
		fail_count    <= fail_total;
		open_count    <= status_due.size();
		checked_count <= checked_total;
		reject_count  <= reject_total;
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives the tone and led sequencer through queue, repeat and counting setups
// with directed and random items and random stalls on both stream sides
// ----------------------------------------------------------------------------
module testbench;
	import tlps_pkg::*;

	// codes with no name in the package
	localparam logic [1:0] KIND_NONE   = 2'd3;
	localparam logic [1:0] MODE_CUSTOM = 2'd2;
	localparam logic [1:0] MODE_SPARE  = 2'd3;

	localparam int NUM_PHASES      = 10;
	localparam int ITEMS_PER_PHASE = 72;
	localparam int FLUSH_TICKS     = 20;
	localparam int HOLD_PHASE      = 1;
	localparam int STEADY_PHASE    = 3;
	localparam int HOLD_CYCLES     = 400;
	localparam int CYCLE_LIMIT     = 500_000;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [39:0]           s_tdata   = '0;
	logic [1:0]            s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [31:0]           m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int fail_count;
	int open_count;
	int checked_count;
	int reject_count;

	// shared between the stimulus and the result-side process
	logic        steady       = 1'b0;
	logic        hold_request = 1'b0;
	logic [15:0] cur_period   = 16'd1;
	int          item_count   = 0;
	int          setup_count  = 0;
	int          cycle_count  = 0;

	tone_and_led_pattern_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	seq_status_checker status_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.open_count    (open_count),
		.checked_count (checked_count),
		.reject_count  (reject_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit, well above the slowest legal run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still open", cycle_count, open_count);
		$display("Test completed with failures");
		$finish;
	end

	// result side: random stalls, one long hold-off on request, none while steady
	initial begin
		int   hold_left;
		logic take;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				take = 1'b0;
			end else begin
				take = steady || ($urandom_range(99) >= 33);
			end
			@(negedge clk);
			m_tready <= take;
		end
	end

	// one register write, valid is left high for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// all four registers, only called with nothing in flight
	task automatic configure(input logic [1:0] mode, input logic buz, input logic led,
			input logic [15:0] period);
		write_reg(CFG_PLAY_MODE, {14'd0, mode});
		write_reg(CFG_BUZ_EN, {15'd0, buz});
		write_reg(CFG_LED_EN, {15'd0, led});
		write_reg(CFG_PERIOD, period);
		cfg_valid  <= 1'b0;
		cur_period  = period;
		setup_count++;
		@(negedge clk);
	endtask

	// offer one item with a random gap in front, returns at the falling edge after accept
	task automatic send_item(input logic [1:0] kind, input logic [15:0] freq,
			input logic [7:0] pat, input logic [15:0] len);
		while (!steady && $urandom_range(99) < 33) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {len, pat, freq};
		do @(posedge clk); while (!s_tready);
		item_count++;
		@(negedge clk);
	endtask

	// stop offering and wait for every predicted result to come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (open_count != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// lengths sized so entries expire within a few ticks at the current period,
	// or the whole 16-bit range when one tick covers it anyway
	function automatic logic [15:0] pick_length(input logic wide);
		int unsigned p;
		int unsigned v;
		if ($urandom_range(19) == 0)
			return 16'd0;
		if (wide)
			return 16'($urandom);
		p = (cur_period == 16'd0) ? 1 : cur_period;
		v = $urandom_range(3) * p + $urandom_range(p - 1);
		return (v > 65535) ? 16'hFFFF : 16'(v);
	endfunction

	// mostly ticks and adds with random content, a little unused-kind noise
	task automatic random_item(input logic wide);
		int          r;
		logic [1:0]  kind;
		logic [15:0] freq;
		r = $urandom_range(99);
		if (r < 50)
			kind = KIND_TICK;
		else if (r < 72)
			kind = KIND_TONE;
		else if (r < 94)
			kind = KIND_LED;
		else
			kind = KIND_NONE;
		freq = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
		send_item(kind, freq, 8'($urandom), pick_length(wide));
	endtask

	initial begin
		int          k;
		logic [1:0]  mode;
		logic        buz;
		logic        led;
		logic [15:0] period;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part: queue mode, one tick spans any length
		configure(MODE_QUEUE, 1'b1, 1'b1, 16'hFFFF);
		// zero length is ignored
		send_item(KIND_TONE, 16'hFFFF, 8'h00, 16'd0);
		// add to an empty channel starts at once, silence keeps the buzzer off
		send_item(KIND_TONE, 16'd0, 8'hFF, 16'd1);
		// fill every tone slot, so later index moves only meet written slots
		for (k = 1; k < STORE_DEPTH; k++)
			send_item(KIND_TONE, (k == STORE_DEPTH - 1) ? 16'hFFFF : 16'($urandom),
				8'($urandom), 16'($urandom_range(1, 3)));
		// full channel refuses
		send_item(KIND_TONE, 16'h1234, 8'h5A, 16'd2);
		send_item(KIND_LED, 16'h0000, 8'hFF, 16'd0);
		send_item(KIND_LED, 16'hFFFF, 8'hFF, 16'd1);
		for (k = 1; k < STORE_DEPTH; k++)
			send_item(KIND_LED, 16'($urandom),
				(k == STORE_DEPTH - 1) ? 8'h00 : 8'($urandom), 16'($urandom_range(1, 3)));
		send_item(KIND_LED, 16'h0000, 8'hA5, 16'd3);
		// unused kind does nothing
		send_item(KIND_NONE, 16'hFFFF, 8'hFF, 16'hFFFF);
		// ticks pop entries and drive the next ones
		repeat (4)
			send_item(KIND_TICK, 16'($urandom), 8'($urandom), 16'($urandom));
		wait_idle();

		// random part, one register setup per phase besides the queue-mode flush setup
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin mode = MODE_REPEAT; buz = 1'b1; led = 1'b1; period = 16'd1; end
				1: begin mode = MODE_QUEUE;  buz = 1'b1; led = 1'b1; period = 16'd0; end
				2: begin mode = MODE_REPEAT; buz = 1'b1; led = 1'b0; period = 16'd2; end
				3: begin mode = MODE_QUEUE;  buz = 1'b0; led = 1'b1; period = 16'd3; end
				4: begin mode = MODE_CUSTOM; buz = 1'b1; led = 1'b1; period = 16'd5; end
				5: begin mode = MODE_SPARE;  buz = 1'b1; led = 1'b1; period = 16'd7; end
				6: begin
					mode = MODE_REPEAT; buz = 1'b1; led = 1'b1;
					period = 16'($urandom_range(8, 40));
				end
				7: begin
					mode = MODE_QUEUE; buz = 1'b1; led = 1'b1;
					period = 16'($urandom_range(8, 40));
				end
				8: begin mode = MODE_REPEAT; buz = 1'b1; led = 1'b1; period = 16'hFFFF; end
				default: begin mode = MODE_QUEUE; buz = 1'b1; led = 1'b1; period = 16'hFFFF; end
			endcase
			// empty both channels in queue mode first, except where a disabled
			// channel should keep the entries of the phase before
			if (ph != 2 && ph != STEADY_PHASE) begin
				configure(MODE_QUEUE, 1'b1, 1'b1, 16'hFFFF);
				repeat (FLUSH_TICKS)
					send_item(KIND_TICK, 16'($urandom), 8'($urandom), 16'($urandom));
				wait_idle();
			end
			configure(mode, buz, led, period);
			steady = (ph == STEADY_PHASE);
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				// long receiver hold-off while items keep coming
				if (ph == HOLD_PHASE && k == 20)
					hold_request = 1'b1;
				random_item(period == 16'hFFFF);
			end
			wait_idle();
			steady = 1'b0;
		end

		// room for a stray late result
		repeat (100) @(posedge clk);

		$display("covered %0d items over %0d register setups, %0d results compared",
			item_count, setup_count, checked_count);
		$display("queue, repeat and counting modes with channels disabled in turn, %0d adds %s",
			reject_count, "refused on a full channel");
		if (fail_count == 0 && open_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> tone_and_led_pattern_sequencer_unit.f
src/tlps_pkg.sv
src/tlps_div.sv
src/tlps_chan.sv
src/tone_and_led_pattern_sequencer_unit.sv
src/tlps_checker.sv
tb/sv/seq_status_checker.sv
tb/sv/testbench.sv
